FILE: sv/ipsfc_pkg.sv
// Shared types and constants for the IPv4 source forwarding classifier.
package ipsfc_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [13:0] MaxFrameBytes = 14'd16383;
  localparam logic [15:0] EthP8021q = 16'h8100;
  localparam logic [15:0] EthP8021ad = 16'h88A8;
  localparam logic [15:0] EthPIp = 16'h0800;
  localparam logic [1:0] OpByte = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  // Search request travelling along the row of cells.
  typedef struct packed {
    logic        active;
    logic [7:0]  port;
    logic [31:0] source;
    logic [13:0] len;
    logic        found;
    logic [7:0]  egress;
  } probe_t;

  typedef struct packed {
    logic        wr;
    logic        en;
    logic [7:0]  port;
    logic [31:0] source;
    logic [7:0]  egress;
  } slot_wr_t;
endpackage

FILE: sv/ipv4_source_forwarding_classifier_core.sv
// Top level: parser, row of table cells, verdict and readback output.
// One input item per start pulse while busy is low. Packet bytes other than
// the last of a frame and writes leave busy low. The last byte of a frame
// raises busy while its search probe walks the row of table cells one cell
// per cycle (twice when the main key misses, once more for the drop entry).
// A counter read's result is registered and appears in the cycle after
// acceptance. Results appear for one cycle on valid_out and cannot be held
// off.
module ipv4_source_forwarding_classifier_core
  import ipsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [7:0]  ingress_port,
  input  logic [3:0]  entry_index,
  input  logic        entry_enable,
  input  logic [7:0]  key_port,
  input  logic [31:0] key_source,
  input  logic [7:0]  egress_value,
  output logic        valid_out,
  output logic        result_kind,
  output logic        forward,
  output logic [7:0]  egress_port,
  output logic [47:0] packet_count,
  output logic [47:0] byte_count
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StParse = 2'd1;
  localparam logic [1:0] StMain = 2'd2;
  localparam logic [1:0] StDrop = 2'd3;

  logic [1:0]  state;
  logic [5:0]  cnt;
  logic        take;
  logic        pdone;
  logic        pok;
  logic [31:0] psrc;
  logic [13:0] plen;
  logic [7:0]  port_hold;
  probe_t      chain [TableEntries+1];
  probe_t      inject;
  slot_wr_t    wr [TableEntries];
  logic [47:0] pk [TableEntries];
  logic [47:0] by [TableEntries];
  logic [13:0] len_hold;
  logic [31:0] src_hold;

  assign take = start && !busy;
  assign busy = state != StIdle;

  ipsfc_parser u_parser (
    .clk, .rst,
    .take(take && opcode == OpByte),
    .data_byte, .last_byte,
    .done(pdone), .ok(pok), .source(psrc), .len(plen)
  );

  always_comb begin
    inject = '0;
    inject.port = port_hold;
    inject.len = len_hold;
    inject.source = src_hold;
    inject.active = (state == StMain || state == StDrop) && cnt == 6'd0;
  end

  assign chain[0] = inject;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    always_comb begin
      wr[g].wr = take && opcode == OpWrite && entry_index == IdxW'(g);
      wr[g].en = entry_enable;
      wr[g].port = key_port;
      wr[g].source = key_source;
      wr[g].egress = egress_value;
    end
    ipsfc_cell u_cell (
      .clk, .rst,
      .wr(wr[g]),
      .probe_in(chain[g]),
      .probe_out(chain[g+1]),
      .packets(pk[g]),
      .bytes_cnt(by[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt <= '0;
      valid_out <= 1'b0;
    end else begin
      valid_out <= 1'b0;
      case (state)
        StIdle: begin
          if (take && opcode == OpByte && last_byte) begin
            state <= StParse;
            port_hold <= ingress_port;
          end else if (take && opcode == OpRead) begin
            valid_out <= 1'b1;
            result_kind <= 1'b1;
            forward <= 1'b0;
            egress_port <= '0;
            packet_count <= pk[entry_index];
            byte_count <= by[entry_index];
          end
        end
        StParse: begin
          if (pdone) begin
            len_hold <= plen;
            cnt <= '0;
            if (pok) begin
              state <= StMain;
              src_hold <= psrc;
            end else begin
              state <= StDrop;
              src_hold <= '0;
            end
          end
        end
        StMain: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(TableEntries)) begin
            cnt <= '0;
            if (chain[TableEntries].found) begin
              state <= StIdle;
              valid_out <= 1'b1;
              result_kind <= 1'b0;
              forward <= 1'b1;
              egress_port <= chain[TableEntries].egress;
              packet_count <= '0;
              byte_count <= '0;
            end else begin
              state <= StDrop;
              src_hold <= '0;
            end
          end
        end
        StDrop: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(TableEntries)) begin
            cnt <= '0;
            state <= StIdle;
            valid_out <= 1'b1;
            result_kind <= 1'b0;
            forward <= 1'b0;
            egress_port <= '0;
            packet_count <= '0;
            byte_count <= '0;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

FILE: sv/ipsfc_cell.sv
// One table slot: key match, counters, and the hand-on of the search probe.
module ipsfc_cell
  import ipsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  slot_wr_t    wr,
  input  probe_t      probe_in,
  output probe_t      probe_out,
  output logic [47:0] packets,
  output logic [47:0] bytes_cnt
);
  logic        valid;
  logic [7:0]  port;
  logic [31:0] source;
  logic [7:0]  egress;
  logic        hit_main;
  logic        count_it;
  probe_t      probe_next;

  assign hit_main = valid && port == probe_in.port && source == probe_in.source;

  always_comb begin
    probe_next = probe_in;
    count_it = 1'b0;
    // Main key takes priority; drop entry only counts if the main key never matched.
    if (probe_in.active && !probe_in.found && hit_main) begin
      probe_next.found = 1'b1;
      probe_next.egress = egress;
      count_it = 1'b1;
    end
  end

  // Drop entry is a separate search: probe carries source=0 when the frame failed parsing or its main key missed.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
      if (wr.wr) begin
        valid <= wr.en;
      end
    end
    if (wr.wr) begin
      port <= wr.port;
      source <= wr.source;
      egress <= wr.egress;
      packets <= '0;
      bytes_cnt <= '0;
    end else if (count_it) begin
      packets <= packets + 48'd1;
      bytes_cnt <= bytes_cnt + {34'd0, probe_in.len};
    end
  end
endmodule

FILE: sv/ipsfc_parser.sv
// Byte-serial Ethernet/IPv4 header parser producing one search key per frame.
module ipsfc_parser
  import ipsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        done,
  output logic        ok,
  output logic [31:0] source,
  output logic [13:0] len
);
  logic [13:0] byte_offset;
  logic [15:0] type_field;
  logic [4:0]  header_start;
  logic [31:0] parsed_source;
  logic [7:0]  parsed_protocol;
  logic [15:0] type_next;
  logic [4:0]  hs_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [13:0] len_next;
  logic [14:0] pos;
  logic [14:0] hs;

  always_comb begin
    pos = {1'b0, byte_offset};
    hs = {10'd0, header_start};
    type_next = type_field;
    hs_next = header_start;
    proto_next = parsed_protocol;
    src_next = parsed_source;
    if (pos == 15'd12 || pos == 15'd13) begin
      type_next = {type_field[7:0], data_byte};
      if (pos == 15'd13 && (type_next == EthP8021q || type_next == EthP8021ad)) begin
        hs_next = 5'd18;
      end
    end else if ((pos == 15'd16 || pos == 15'd17) && hs == 15'd18) begin
      type_next = {type_field[7:0], data_byte};
    end
    if (pos == hs + 15'd9) begin
      proto_next = data_byte;
    end
    if (pos >= hs + 15'd12 && pos < hs + 15'd16) begin
      src_next = {parsed_source[23:0], data_byte};
    end
    len_next = (byte_offset == MaxFrameBytes) ? MaxFrameBytes : byte_offset + 14'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      type_field <= '0;
      header_start <= 5'd14;
      parsed_source <= '0;
      parsed_protocol <= '0;
      done <= 1'b0;
    end else begin
      done <= take && last_byte;
      if (take) begin
        if (last_byte) begin
          byte_offset <= '0;
          type_field <= '0;
          header_start <= 5'd14;
          parsed_source <= '0;
          parsed_protocol <= '0;
        end else begin
          byte_offset <= len_next;
          type_field <= type_next;
          header_start <= hs_next;
          parsed_source <= src_next;
          parsed_protocol <= proto_next;
        end
      end
    end
    if (take && last_byte) begin
      ok <= len_next >= 14'd14 && type_next == EthPIp &&
            len_next >= {9'd0, hs_next} + 14'd20 && proto_next != 8'd0;
      source <= src_next;
      len <= len_next;
    end
  end
endmodule

FILE: bench/tb_top.sv
// Testbench for the IPv4 source forwarding classifier: random frames and table traffic, scoreboard.
`timescale 1ns / 100ps
module tb_top;
  import ipsfc_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  port;
    logic [3:0]  idx;
    logic        en;
    logic [7:0]  kport;
    logic [31:0] ksrc;
    logic [7:0]  egr;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic        fwd;
    logic [7:0]  egr;
    logic [47:0] pkts;
    logic [47:0] bytes;
  } verdict_t;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, valid_out, result_kind, forward;
  logic [7:0] egress_port;
  logic [47:0] packet_count, byte_count;
  cmd_t cur_cmd = '0;

  cmd_t pending_cmds[$];
  verdict_t expected_verdicts[$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predictor state
  int unsigned p_offset = 0;
  logic [15:0] p_type = '0;
  int unsigned p_hstart = 14;
  logic [31:0] p_src = '0;
  logic [7:0]  p_proto = '0;
  logic        t_valid [TableEntries];
  logic [7:0]  t_port  [TableEntries];
  logic [31:0] t_src   [TableEntries];
  logic [7:0]  t_egr   [TableEntries];
  logic [47:0] t_pkts  [TableEntries];
  logic [47:0] t_bytes [TableEntries];

  logic [7:0]  port_pool [4] = '{8'd3, 8'd0, 8'd255, 8'd77};
  logic [31:0] src_pool  [6] = '{32'h0, 32'hC0A80001, 32'hFFFFFFFF, 32'h0A000005,
                                 32'h7F000001, 32'h80000000};

  ipv4_source_forwarding_classifier_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(cur_cmd.op), .data_byte(cur_cmd.data), .last_byte(cur_cmd.last),
    .ingress_port(cur_cmd.port), .entry_index(cur_cmd.idx),
    .entry_enable(cur_cmd.en), .key_port(cur_cmd.kport), .key_source(cur_cmd.ksrc),
    .egress_value(cur_cmd.egr), .valid_out(valid_out), .result_kind(result_kind),
    .forward(forward), .egress_port(egress_port), .packet_count(packet_count),
    .byte_count(byte_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int lookup_slot(logic [7:0] port, logic [31:0] src);
    for (int i = 0; i < TableEntries; i++)
      if (t_valid[i] && t_port[i] == port && t_src[i] == src) return i;
    return -1;
  endfunction

  function automatic void tally_frame(int i, int unsigned len);
    t_pkts[i] = t_pkts[i] + 48'd1;
    t_bytes[i] = t_bytes[i] + 48'(len);
  endfunction

  function automatic void classify_cmd(cmd_t c);
    verdict_t v;
    int unsigned pos, len, hs;
    int hit;
    v = '0;
    if (c.op == OpWrite) begin
      t_valid[c.idx] = c.en;
      t_port[c.idx] = c.kport;
      t_src[c.idx] = c.ksrc;
      t_egr[c.idx] = c.egr;
      t_pkts[c.idx] = '0;
      t_bytes[c.idx] = '0;
    end else if (c.op == OpRead) begin
      v.kind = 1'b1;
      v.pkts = t_pkts[c.idx];
      v.bytes = t_bytes[c.idx];
      expected_verdicts.push_back(v);
    end else if (c.op == OpByte) begin
      pos = p_offset;
      hs = p_hstart;
      if (pos == 12 || pos == 13) begin
        p_type = {p_type[7:0], c.data};
        if (pos == 13 && (p_type == EthP8021q || p_type == EthP8021ad)) p_hstart = 18;
      end else if ((pos == 16 || pos == 17) && hs == 18) begin
        p_type = {p_type[7:0], c.data};
      end
      if (pos == hs + 9) p_proto = c.data;
      if (pos >= hs + 12 && pos < hs + 16) p_src = {p_src[23:0], c.data};
      len = pos + 1;
      if (len > MaxFrameBytes) len = MaxFrameBytes;
      p_offset = len;
      if (c.last) begin
        hit = -1;
        if (len >= 14 && p_type == EthPIp && len >= p_hstart + 20 && p_proto != 0)
          hit = lookup_slot(c.port, p_src);
        if (hit >= 0) begin
          tally_frame(hit, len);
          v.fwd = 1'b1;
          v.egr = t_egr[hit];
        end else begin
          hit = lookup_slot(c.port, 32'h0);
          if (hit >= 0) tally_frame(hit, len);
        end
        expected_verdicts.push_back(v);
        p_offset = 0;
        p_type = '0;
        p_hstart = 14;
        p_src = '0;
        p_proto = '0;
      end
    end
  endfunction

  // random filler for the fields an operation ignores
  function automatic cmd_t noise_cmd(logic [1:0] op);
    cmd_t c;
    c.op = op;
    c.data = 8'($urandom);
    c.last = 1'b0;
    c.port = 8'($urandom);
    c.idx = 4'($urandom);
    c.en = 1'($urandom);
    c.kport = 8'($urandom);
    c.ksrc = $urandom;
    c.egr = 8'($urandom);
    return c;
  endfunction

  task automatic push_write(int idx, logic en, logic [7:0] kp, logic [31:0] ks,
                            logic [7:0] eg);
    cmd_t c;
    c = noise_cmd(OpWrite);
    c.idx = 4'(idx);
    c.en = en;
    c.kport = kp;
    c.ksrc = ks;
    c.egr = eg;
    pending_cmds.push_back(c);
  endtask

  task automatic push_read(int idx);
    cmd_t c;
    c = noise_cmd(OpRead);
    c.idx = 4'(idx);
    pending_cmds.push_back(c);
  endtask

  task automatic push_random_write();
    push_write($urandom_range(TableEntries - 1), ($urandom_range(9) != 0),
               port_pool[$urandom_range(3)], src_pool[$urandom_range(5)], 8'($urandom));
  endtask

  task automatic push_bytes(logic [7:0] bytes[$], logic [7:0] port, bit mix);
    cmd_t c;
    foreach (bytes[i]) begin
      if (mix && $urandom_range(99) < 3) begin
        case ($urandom_range(2))
          0: push_random_write();
          1: push_read($urandom_range(TableEntries - 1));
          default: pending_cmds.push_back(noise_cmd(OpNone));
        endcase
      end
      c = noise_cmd(OpByte);
      c.data = bytes[i];
      c.last = (i == bytes.size() - 1);
      // ingress port matters only on the final byte
      if (c.last || $urandom_range(1)) c.port = port;
      pending_cmds.push_back(c);
    end
  endtask

  // tag: 0 none, else the tag ethertype
  task automatic push_frame(logic [7:0] port, logic [15:0] tag, logic [15:0] etype,
                            logic [7:0] proto, logic [31:0] src, int extra, bit mix);
    logic [7:0] b[$];
    for (int i = 0; i < 12; i++) b.push_back(8'($urandom));
    if (tag != 16'h0) begin
      b.push_back(tag[15:8]); b.push_back(tag[7:0]);
      b.push_back(8'($urandom)); b.push_back(8'($urandom));
    end
    b.push_back(etype[15:8]); b.push_back(etype[7:0]);
    for (int i = 0; i < 20; i++) begin
      if (i == 9) b.push_back(proto);
      else if (i >= 12 && i < 16) b.push_back(src[8 * (15 - i) +: 8]);
      else b.push_back(8'($urandom));
    end
    for (int i = 0; i < extra; i++) b.push_back(8'($urandom));
    push_bytes(b, port, mix);
  endtask

  task automatic push_random_frame();
    logic [15:0] tag, et;
    logic [7:0] proto, bq[$];
    int r;
    int n;
    r = $urandom_range(99);
    tag = ($urandom_range(2) == 0) ? 16'h0 : ($urandom_range(1) ? EthP8021q : EthP8021ad);
    et = EthPIp;
    proto = 8'($urandom_range(255, 1));
    if (r < 10) et = 16'($urandom);
    else if (r < 15) proto = 8'h0;
    if (r >= 15 && r < 22) begin
      // short or truncated frame, possibly with a valid prefix
      n = $urandom_range(40, 1);
      for (int i = 0; i < n; i++)
        bq.push_back((i == 12) ? 8'h08 : ((i == 13) ? 8'h00 : 8'($urandom)));
      push_bytes(bq, port_pool[$urandom_range(3)], 1);
    end else begin
      push_frame(port_pool[$urandom_range(3)], tag, et, proto,
                 ($urandom_range(9) == 0) ? $urandom : src_pool[$urandom_range(5)],
                 $urandom_range(6), 1);
    end
  endtask

  // driver: predict on each accepted transfer, then present the next item
  always @(posedge clk) begin
    logic idle;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) classify_cmd(cur_cmd);
      if (!(start && busy)) begin
        idle = !(sent_cnt >= 500 && sent_cnt < 800) && ($urandom_range(99) < 31);
        if (pending_cmds.size() != 0 && !idle) begin
          cur_cmd <= pending_cmds.pop_front();
          start <= 1'b1;
          sent_cnt <= sent_cnt + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && valid_out) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result kind %0h", result_kind);
        err_cnt++;
      end else begin
        e = expected_verdicts.pop_front();
        if (result_kind !== e.kind) begin
          $error("result_kind exp %0h got %0h", e.kind, result_kind); err_cnt++;
        end
        if (forward !== e.fwd) begin
          $error("forward exp %0h got %0h", e.fwd, forward); err_cnt++;
        end
        if (egress_port !== e.egr) begin
          $error("egress_port exp %0h got %0h", e.egr, egress_port); err_cnt++;
        end
        if (packet_count !== e.pkts) begin
          $error("packet_count exp %0h got %0h", e.pkts, packet_count); err_cnt++;
        end
        if (byte_count !== e.bytes) begin
          $error("byte_count exp %0h got %0h", e.bytes, byte_count); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("ipv4_source_forwarding_classifier_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] short_b[$];
    for (int i = 0; i < TableEntries; i++) begin
      t_valid[i] = 1'b0; t_port[i] = '0; t_src[i] = '0;
      t_egr[i] = '0; t_pkts[i] = '0; t_bytes[i] = '0;
    end
    // fill every slot first so no read ever hits a slot never written
    for (int i = 0; i < TableEntries; i++)
      push_write(i, 1'b1, port_pool[i % 4], src_pool[i % 6], 8'(i * 17));
    push_write(15, 1'b1, 8'hFF, 32'hFFFFFFFF, 8'hFF);
    push_write(0, 1'b1, 8'h03, 32'h0, 8'h00);
    push_frame(8'h03, 16'h0, EthPIp, 8'h06, 32'hC0A80001, 0, 0);
    push_frame(8'hFF, EthP8021q, EthPIp, 8'hFF, 32'hFFFFFFFF, 2, 0);
    push_frame(8'h00, EthP8021ad, EthPIp, 8'h11, 32'h0A000005, 0, 0);
    push_frame(8'h03, 16'h0, EthPIp, 8'h00, 32'hC0A80001, 0, 0);
    push_frame(8'h03, 16'h0, EthPIp, 8'h01, 32'h0, 1, 0);
    short_b = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    push_bytes(short_b, 8'h03, 0);
    pending_cmds.push_back(noise_cmd(OpNone));
    push_read(0);
    push_read(15);
    push_read(6);
    while (pending_cmds.size() < 1334) begin
      case ($urandom_range(9))
        0: push_random_write();
        1: push_read($urandom_range(TableEntries - 1));
        default: push_random_frame();
      endcase
    end
    for (int i = 0; i < TableEntries; i++) push_read(i);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && !start && expected_verdicts.size() == 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("ipv4_source_forwarding_classifier_core: match");
    end else begin
      $display("ipv4_source_forwarding_classifier_core: mismatch");
    end
    $finish;
  end
endmodule
